>>> hw/rtl/otrb_pkg.sv
// Shared constants and types for the overwriting trace ring buffer.
`timescale 1ns / 1ps

package otrb_pkg;

    localparam int CAPACITY    = 256;
    localparam int ENTRY_WIDTH = 64;
    localparam int MAX_PAGE    = 64;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = $clog2(MAX_PAGE + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_FREEZE = 2'd1,
        KIND_PAGE   = 2'd2,
        KIND_STATS  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RES_ENTRY = 2'd0,
        RES_EMPTY = 2'd1,
        RES_STATS = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/overwriting_trace_ring_buffer.sv
// Top level: capture ring, page replay sequencer and result register.
// Write and freeze requests may follow back to back while the sequencer is idle.
// Statistics and empty-page requests: result valid the cycle after acceptance.
// Read page: each replayed entry steps through address via the shared ring
// adder, registered RAM read and result load, then waits for the result taker.
// Synchronous active-low reset clears pointer, counters, done and valid flags and
// sets capture on; the entry RAM is not cleared and is never read before written.
`timescale 1ns / 1ps

module overwriting_trace_ring_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_entry_word,
    input  logic [7:0]  i_page_offset,
    input  logic [6:0]  i_page_limit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_entry_out,
    output logic [7:0]  o_entry_position,
    output logic [8:0]  o_stored_total,
    output logic [31:0] o_dropped_total,
    output logic        o_capture_on,
    output logic        o_capture_done,
    output logic        o_last
);

    import otrb_pkg::*;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_oldest;
    logic [CNT_W-1:0]       r_fill;
    logic [31:0]            r_drops;
    logic                   r_capturing;
    logic                   r_completed;
    logic [ADDR_W-1:0]      r_pos;
    logic [LIM_W-1:0]       r_left;
    logic                   r_out_valid;
    t_rkind                 r_rkind;
    logic [ENTRY_WIDTH-1:0] r_entry;
    logic [ADDR_W-1:0]      r_opos;
    logic                   r_last;

    logic                   in_acc;
    logic                   out_acc;
    t_kind                  kind;
    logic                   full;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      addend;
    logic [ADDR_W:0]        sum;
    logic [ADDR_W-1:0]      ring_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;

    logic [CMP_W-1:0]       off_x;
    logic [CMP_W-1:0]       fill_x;
    logic [CMP_W-1:0]       avail;
    logic [LIM_W-1:0]       lim;
    logic [LIM_W-1:0]       wanted;
    logic                   page_empty;
    logic [ADDR_W+7:0]      opos_x;
    logic [CNT_W+8:0]       fill_o;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign kind    = t_kind'(i_kind);
    assign full    = (r_fill == CNT_W'(CAPACITY));

    // Page bounds: clamp limit, then limit against what is stored past the offset.
    always_comb begin
        off_x  = CMP_W'(i_page_offset);
        fill_x = CMP_W'(r_fill);
        avail  = fill_x - off_x;
        if (i_page_limit > 7'(MAX_PAGE)) begin
            lim = LIM_W'(MAX_PAGE);
        end else begin
            lim = i_page_limit[LIM_W-1:0];
        end
        if (CMP_W'(lim) < avail) begin
            wanted = lim;
        end else begin
            wanted = avail[LIM_W-1:0];
        end
        page_empty = (lim == '0) || (off_x >= fill_x);
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (kind == KIND_PAGE)) begin
                    n_state = page_empty ? ST_EMIT : ST_READ;
                end else if (in_acc && (kind == KIND_STATS)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_acc) begin
                    n_state = (r_left != '0) ? ST_READ : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control decode
    always_comb begin
        wr_en  = 1'b0;
        rd_en  = 1'b0;
        addend = r_pos;
        case (r_state)
            ST_IDLE: begin
                wr_en  = in_acc && (kind == KIND_WRITE) && r_capturing;
                addend = full ? '0 : r_fill[ADDR_W-1:0];
            end
            ST_READ: rd_en = 1'b1;
            default: ;
        endcase
    end

    // Shared ring adder: oldest plus fill or read offset, wrapped once at capacity.
    always_comb begin
        sum = {1'b0, r_oldest} + {1'b0, addend};
        if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
            ring_addr = ADDR_W'(sum - (ADDR_W + 1)'(CAPACITY));
        end else begin
            ring_addr = sum[ADDR_W-1:0];
        end
    end

    otrb_ram #(
        .WIDTH(ENTRY_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_rd_en  (rd_en),
        .i_addr   (ring_addr),
        .i_wr_data(i_entry_word[ENTRY_WIDTH-1:0]),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_drops     <= '0;
            r_capturing <= 1'b1;
            r_completed <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                if (full) begin
                    // Overwrite oldest: advance it and count the drop.
                    r_oldest <= (r_oldest == ADDR_W'(CAPACITY - 1)) ? '0
                                                                    : r_oldest + 1'b1;
                    if (r_drops != 32'hFFFF_FFFF) begin
                        r_drops <= r_drops + 32'd1;
                    end
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == ST_IDLE && in_acc && kind == KIND_FREEZE) begin
                r_capturing <= 1'b0;
                r_completed <= 1'b1;
            end
            if (r_state == ST_IDLE && in_acc && kind == KIND_PAGE) begin
                r_left      <= page_empty ? '0 : wanted;
                r_out_valid <= page_empty;
            end else if (r_state == ST_IDLE && in_acc && kind == KIND_STATS) begin
                r_left      <= '0;
                r_out_valid <= 1'b1;
            end else if (r_state == ST_LOAD) begin
                r_left      <= r_left - 1'b1;
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_pos   <= off_x[ADDR_W-1:0];
            r_entry <= '0;
            r_opos  <= '0;
            r_last  <= 1'b1;
            r_rkind <= (kind == KIND_STATS) ? RES_STATS : RES_EMPTY;
        end else if (r_state == ST_LOAD) begin
            r_entry <= rd_data;
            r_opos  <= r_pos;
            r_last  <= (r_left == LIM_W'(1));
            r_rkind <= RES_ENTRY;
            r_pos   <= r_pos + 1'b1;
        end
    end

    assign opos_x = {8'd0, r_opos};
    assign fill_o = {9'd0, r_fill};

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_rkind;
    assign o_entry_out      = 64'(r_entry);
    assign o_entry_position = opos_x[7:0];
    assign o_stored_total   = fill_o[8:0];
    assign o_dropped_total  = r_drops;
    assign o_capture_on     = r_capturing;
    assign o_capture_done   = r_completed;
    assign o_last           = r_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drops != 32'd0) |-> full)
        else $error("drops counted while ring not full");

    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT))
        else $error("result valid outside emit state");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_out_valid && r_rkind == RES_ENTRY))
        else $error("loaded entry not presented");

endmodule

>>> hw/rtl/otrb_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module otrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
